// ===== rtl/core/pgp_pkg.sv =====
package pgp_pkg;

  // Register map
  typedef enum logic [1:0] {
    CFG_FOCAL_X  = 2'd0,
    CFG_FOCAL_Y  = 2'd1,
    CFG_CENTER_X = 2'd2,
    CFG_CENTER_Y = 2'd3
  } cfg_idx_t;

  localparam int CFG_W    = 12;
  localparam int PIX_W    = 12;
  localparam int Q_W      = 16;
  localparam int POS_W    = 24;

  localparam logic [CFG_W-1:0] FOCAL_RST    = 12'd536;
  localparam logic [CFG_W-1:0] CENTER_X_RST = 12'd640;
  localparam logic [CFG_W-1:0] CENTER_Y_RST = 12'd360;

  // Rotation datapath widths
  localparam int V_W  = PIX_W + 1;      // centred pixel offset
  localparam int U_W  = Q_W + 1;        // negated vector part
  localparam int P_W  = U_W + V_W;      // u * v products
  localparam int T_W  = 32;             // t = 2 (u x v)
  localparam int M_W  = U_W + T_W;      // w*t and u*t products
  localparam int R_W  = 50;             // rotated component, Q28
  localparam int FRAC = 14;

  // Projection datapath widths
  localparam int CM_W    = R_W - FRAC;  // |component| in Q14
  localparam int CM_LO   = CM_W / 2;
  localparam int PP_W    = POS_W + CM_LO;
  localparam int PROD_W  = POS_W + CM_W;
  localparam int N_W     = PROD_W + 1 - FRAC;
  localparam int DIV_BITS = 25;         // quotient bits before saturation
  localparam int HI_W    = N_W - DIV_BITS;
  localparam int OFF_W   = DIV_BITS + 2;
  localparam int SUM_W   = OFF_W + 1;

  localparam int FRONT_LAT = 5;
  localparam int AX_LAT    = 5 + DIV_BITS;
  localparam int PIPE_LAT  = FRONT_LAT + AX_LAT;

endpackage

// ===== rtl/core/pgp_axis.sv =====
module pgp_axis import pgp_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [R_W-1:0]   r_in,
  input  logic signed [POS_W-1:0] h_in,
  input  logic signed [POS_W-1:0] pos_in,
  input  logic [CFG_W-1:0]        focal,
  output logic signed [POS_W-1:0] ground
);

  // Stage 1: round component to Q14, split into sign and magnitude
  logic                    a1_neg_r, a1_neg_nxt;
  logic [CM_W-1:0]         a1_cm_r, a1_cm_nxt;
  logic [POS_W-1:0]        a1_hm_r, a1_hm_nxt;
  logic signed [POS_W-1:0] a1_pos_r;
  logic [R_W-1:0]          rmag;
  logic [R_W-1:0]          rrnd;

  always_comb begin
    rmag       = r_in[R_W-1] ? R_W'(-r_in) : R_W'(r_in);
    rrnd       = rmag + R_W'(1 << (FRAC - 1));
    a1_cm_nxt  = rrnd[R_W-1:FRAC];
    a1_hm_nxt  = h_in[POS_W-1] ? POS_W'(-h_in) : POS_W'(h_in);
    a1_neg_nxt = r_in[R_W-1] ^ h_in[POS_W-1];
  end

  // Stage 2: partial products of |h| * |component|
  logic [PP_W-1:0]         a2_lo_r, a2_hi_r;
  logic                    a2_neg_r;
  logic signed [POS_W-1:0] a2_pos_r;

  // Stage 3: add rounding bias, drop the Q14 scale
  logic [N_W-1:0]          a3_n_r, a3_n_nxt;
  logic                    a3_neg_r;
  logic signed [POS_W-1:0] a3_pos_r;
  logic [PROD_W:0]         biased;

  always_comb begin
    biased   = (PROD_W+1)'({a2_hi_r, {CM_LO{1'b0}}}) + (PROD_W+1)'(a2_lo_r)
             + (PROD_W+1)'({focal, {(FRAC-1){1'b0}}});
    a3_n_nxt = biased[PROD_W:FRAC];
  end

  // Divider array, index 0 is the setup stage
  logic [CFG_W-1:0]        rem_r [0:DIV_BITS];
  logic [DIV_BITS-1:0]     nb_r  [0:DIV_BITS];
  logic [DIV_BITS-1:0]     q_r   [0:DIV_BITS];
  logic                    neg_r [0:DIV_BITS];
  logic                    sat_r [0:DIV_BITS];
  logic                    zf_r  [0:DIV_BITS];
  logic signed [POS_W-1:0] pos_r [0:DIV_BITS];
  logic [HI_W-1:0]         hi;
  logic                    sat0;

  assign hi   = a3_n_r[N_W-1:DIV_BITS];
  assign sat0 = hi >= HI_W'(focal);

  always_ff @(posedge clk) begin
    if (en) begin
      a1_neg_r <= a1_neg_nxt;
      a1_cm_r  <= a1_cm_nxt;
      a1_hm_r  <= a1_hm_nxt;
      a1_pos_r <= pos_in;
      a2_lo_r  <= PP_W'(a1_hm_r) * PP_W'(a1_cm_r[CM_LO-1:0]);
      a2_hi_r  <= PP_W'(a1_hm_r) * PP_W'(a1_cm_r[CM_W-1:CM_LO]);
      a2_neg_r <= a1_neg_r;
      a2_pos_r <= a1_pos_r;
      a3_n_r   <= a3_n_nxt;
      a3_neg_r <= a2_neg_r;
      a3_pos_r <= a2_pos_r;
      rem_r[0] <= sat0 ? '0 : hi[CFG_W-1:0];
      nb_r[0]  <= a3_n_r[DIV_BITS-1:0];
      q_r[0]   <= '0;
      neg_r[0] <= a3_neg_r;
      sat_r[0] <= sat0;
      zf_r[0]  <= (focal == '0);
      pos_r[0] <= a3_pos_r;
    end
  end

  // One quotient bit per stage: shift in a dividend bit, subtract if it fits
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    logic [CFG_W:0] trial;
    logic           fits;
    assign trial = {rem_r[k], nb_r[k][DIV_BITS-1]};
    assign fits  = trial >= {1'b0, focal};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= fits ? CFG_W'(trial - {1'b0, focal}) : trial[CFG_W-1:0];
        nb_r[k+1]  <= {nb_r[k][DIV_BITS-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][DIV_BITS-2:0], fits};
        neg_r[k+1] <= neg_r[k];
        sat_r[k+1] <= sat_r[k];
        zf_r[k+1]  <= zf_r[k];
        pos_r[k+1] <= pos_r[k];
      end
    end
  end

  // Final stage: apply sign, add position, clamp
  logic [DIV_BITS:0]       qm;
  logic signed [OFF_W-1:0] off;
  logic signed [SUM_W-1:0] sum;
  logic signed [POS_W-1:0] ground_r, ground_nxt;

  always_comb begin
    qm = sat_r[DIV_BITS] ? (DIV_BITS+1)'(1 << DIV_BITS) : {1'b0, q_r[DIV_BITS]};
    if (zf_r[DIV_BITS])
      off = '0;
    else if (neg_r[DIV_BITS])
      off = -$signed(OFF_W'(qm));
    else
      off = $signed(OFF_W'(qm));
    sum = SUM_W'(pos_r[DIV_BITS]) + SUM_W'(off);
    if (sum > SUM_W'(signed'({1'b0, {(POS_W-1){1'b1}}})))
      ground_nxt = {1'b0, {(POS_W-1){1'b1}}};
    else if (sum < SUM_W'(signed'({1'b1, {(POS_W-1){1'b0}}})))
      ground_nxt = {1'b1, {(POS_W-1){1'b0}}};
    else
      ground_nxt = sum[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) ground_r <= ground_nxt;
  end

  assign ground = ground_r;

endmodule

// ===== rtl/core/pixel_to_ground_projection_unit.sv =====
// Pixel to ground projection.
// Input channel (in_valid/in_ready): one image point per transfer with the
// camera attitude quaternion (Q2.14) and the vehicle position and height
// (1/1024 m). The pixel ray is rotated by the conjugate quaternion and
// scaled by height over focal length onto the ground plane.
// Output channel (out_valid/out_ready): one ground point per input point,
// saturated to 24 bits, in input order, with last_out copied from last_in.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (focal_x, focal_y, center_x, center_y); write only while the pipe is empty.
// Pipeline: five rotation stages, four projection stages, a 25-stage
// restoring divider (one quotient bit per stage, divisor is the focal
// length) and the clamp stage.
// Throughput: one point per cycle while the output is not stalled.
// Reset clears every valid bit and loads the default camera registers.
// A stalled receiver freezes the whole pipe; in_ready drops only while a
// result waits at the output and out_ready is low.
module pixel_to_ground_projection_unit import pgp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PIX_W-1:0]        in_pixel_col,
  input  logic [PIX_W-1:0]        in_pixel_row,
  input  logic signed [Q_W-1:0]   in_quat_w,
  input  logic signed [Q_W-1:0]   in_quat_x,
  input  logic signed [Q_W-1:0]   in_quat_y,
  input  logic signed [Q_W-1:0]   in_quat_z,
  input  logic signed [POS_W-1:0] in_pose_east,
  input  logic signed [POS_W-1:0] in_pose_north,
  input  logic signed [POS_W-1:0] in_pose_height,
  input  logic                    in_last_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] out_ground_east,
  output logic signed [POS_W-1:0] out_ground_north,
  output logic                    out_last_out
);

  // Camera registers
  logic [CFG_W-1:0] focal_x_r, focal_y_r, center_x_r, center_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= FOCAL_RST;
      focal_y_r  <= FOCAL_RST;
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FOCAL_X:  focal_x_r  <= cfg_data;
        CFG_FOCAL_Y:  focal_y_r  <= cfg_data;
        CFG_CENTER_X: center_x_r <= cfg_data;
        CFG_CENTER_Y: center_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: the pipe moves unless the output holds a waiting result
  logic en;
  logic [PIPE_LAT-1:0] vld_r, last_r;

  assign en       = !vld_r[PIPE_LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) last_r <= {last_r[PIPE_LAT-2:0], in_last_in};
  end

  // Stage 0: centre the pixel, negate the vector part
  logic signed [V_W-1:0]   s0_v0_r, s0_v1_r;
  logic signed [U_W-1:0]   s0_u0_r, s0_u1_r, s0_u2_r;
  logic signed [Q_W-1:0]   s0_w_r;
  logic signed [POS_W-1:0] pe_r [0:FRONT_LAT-1];
  logic signed [POS_W-1:0] pn_r [0:FRONT_LAT-1];
  logic signed [POS_W-1:0] ph_r [0:FRONT_LAT-1];

  // Stage 1: u * v products
  logic signed [P_W-1:0]   s1_pa_r, s1_pc_r, s1_pd_r, s1_pe_r;
  logic signed [U_W-1:0]   s1_u0_r, s1_u1_r, s1_u2_r;
  logic signed [Q_W-1:0]   s1_w_r;
  logic signed [V_W-1:0]   s1_v0_r, s1_v1_r;

  // Stage 2: t = 2 (u x v)
  logic signed [T_W-1:0]   s2_t0_r, s2_t1_r, s2_t2_r;
  logic signed [U_W-1:0]   s2_u0_r, s2_u1_r, s2_u2_r;
  logic signed [Q_W-1:0]   s2_w_r;
  logic signed [V_W-1:0]   s2_v0_r, s2_v1_r;

  // Stage 3: w*t and u*t products
  logic signed [M_W-1:0]   s3_m0_r, s3_m1_r, s3_m2_r, s3_m3_r, s3_m4_r, s3_m5_r;
  logic signed [V_W-1:0]   s3_v0_r, s3_v1_r;

  // Stage 4: rotated components in Q28
  logic signed [R_W-1:0]   s4_r0_r, s4_r1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_v0_r <= $signed({1'b0, center_y_r}) - $signed({1'b0, in_pixel_row});
      s0_v1_r <= $signed({1'b0, center_x_r}) - $signed({1'b0, in_pixel_col});
      s0_u0_r <= -U_W'(in_quat_x);
      s0_u1_r <= -U_W'(in_quat_y);
      s0_u2_r <= -U_W'(in_quat_z);
      s0_w_r  <= in_quat_w;
      pe_r[0] <= in_pose_east;
      pn_r[0] <= in_pose_north;
      ph_r[0] <= in_pose_height;

      s1_pa_r <= P_W'(s0_u2_r) * P_W'(s0_v1_r);
      s1_pc_r <= P_W'(s0_u2_r) * P_W'(s0_v0_r);
      s1_pd_r <= P_W'(s0_u0_r) * P_W'(s0_v1_r);
      s1_pe_r <= P_W'(s0_u1_r) * P_W'(s0_v0_r);
      s1_u0_r <= s0_u0_r;
      s1_u1_r <= s0_u1_r;
      s1_u2_r <= s0_u2_r;
      s1_w_r  <= s0_w_r;
      s1_v0_r <= s0_v0_r;
      s1_v1_r <= s0_v1_r;

      s2_t0_r <= (T_W'(s1_u1_r) - T_W'(s1_pa_r)) <<< 1;
      s2_t1_r <= (T_W'(s1_pc_r) - T_W'(s1_u0_r)) <<< 1;
      s2_t2_r <= (T_W'(s1_pd_r) - T_W'(s1_pe_r)) <<< 1;
      s2_u0_r <= s1_u0_r;
      s2_u1_r <= s1_u1_r;
      s2_u2_r <= s1_u2_r;
      s2_w_r  <= s1_w_r;
      s2_v0_r <= s1_v0_r;
      s2_v1_r <= s1_v1_r;

      s3_m0_r <= M_W'(s2_w_r)  * M_W'(s2_t0_r);
      s3_m1_r <= M_W'(s2_u1_r) * M_W'(s2_t2_r);
      s3_m2_r <= M_W'(s2_u2_r) * M_W'(s2_t1_r);
      s3_m3_r <= M_W'(s2_w_r)  * M_W'(s2_t1_r);
      s3_m4_r <= M_W'(s2_u2_r) * M_W'(s2_t0_r);
      s3_m5_r <= M_W'(s2_u0_r) * M_W'(s2_t2_r);
      s3_v0_r <= s2_v0_r;
      s3_v1_r <= s2_v1_r;

      s4_r0_r <= (R_W'(s3_v0_r) <<< (2 * FRAC)) + R_W'(s3_m0_r) + R_W'(s3_m1_r)
               - R_W'(s3_m2_r);
      s4_r1_r <= (R_W'(s3_v1_r) <<< (2 * FRAC)) + R_W'(s3_m3_r) + R_W'(s3_m4_r)
               - R_W'(s3_m5_r);
    end
  end

  // Carry the pose alongside the rotation stages
  for (genvar k = 1; k < FRONT_LAT; k++) begin : g_pose
    always_ff @(posedge clk) begin
      if (en) begin
        pe_r[k] <= pe_r[k-1];
        pn_r[k] <= pn_r[k-1];
        ph_r[k] <= ph_r[k-1];
      end
    end
  end

  // Projection per axis: east uses focal_y, north uses focal_x
  pgp_axis u_axis_east (
    .clk    (clk),
    .en     (en),
    .r_in   (s4_r0_r),
    .h_in   (ph_r[FRONT_LAT-1]),
    .pos_in (pe_r[FRONT_LAT-1]),
    .focal  (focal_y_r),
    .ground (out_ground_east)
  );

  pgp_axis u_axis_north (
    .clk    (clk),
    .en     (en),
    .r_in   (s4_r1_r),
    .h_in   (ph_r[FRONT_LAT-1]),
    .pos_in (pn_r[FRONT_LAT-1]),
    .focal  (focal_x_r),
    .ground (out_ground_north)
  );

  assign out_valid    = vld_r[PIPE_LAT-1];
  assign out_last_out = last_r[PIPE_LAT-1];

`ifndef SYNTHESIS
  // A waiting result must hold the whole pipe
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // An item one stage from the end reaches the output after an advance
  a_valid_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[PIPE_LAT-2] |=> out_valid)
    else $error("item lost before output");

  // An accepted item enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted item not captured");
`endif

endmodule
